// File: rtl/fmcr_pkg.sv
// Shared types, codes and constants of the filtered meter and counter readout.
package fmcr_pkg;

  // Field widths
  localparam int unsigned ReadingW = 10;
  localparam int unsigned OpW      = 2;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CountW   = 7;
  localparam int unsigned AvgW     = 16;
  localparam int unsigned AlphaW   = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Operation codes carried on tuser
  localparam logic [OpW-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OpW-1:0] OP_MODE      = 2'd1;
  localparam logic [OpW-1:0] OP_PULSE     = 2'd2;
  localparam logic [OpW-1:0] OP_CNT_RESET = 2'd3;

  // Display modes
  localparam logic [ModeW-1:0] MODE_UP     = 2'd0;
  localparam logic [ModeW-1:0] MODE_DOWN   = 2'd1;
  localparam logic [ModeW-1:0] MODE_VALUES = 2'd2;
  localparam logic [ModeW-1:0] MODE_VOLTS  = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_ALPHA   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FLOOR   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CEILING = 2'd2;

  // Register reset values
  localparam logic [AlphaW-1:0] ALPHA_RESET   = 8'd2;
  localparam logic [CountW-1:0] FLOOR_RESET   = 7'd0;
  localparam logic [CountW-1:0] CEILING_RESET = 7'd99;
  localparam logic [CountW-1:0] COUNT_MAX     = 7'd99;

  // Mode switch thresholds
  localparam logic [ReadingW-1:0] THR_UP     = 10'd300;
  localparam logic [ReadingW-1:0] THR_DOWN   = 10'd600;
  localparam logic [ReadingW-1:0] THR_VALUES = 10'd850;

  // Value meter: clamp and divide by 25 (reciprocal 41/1024)
  localparam logic [ByteW-1:0] VALUE_MAX = 8'd249;
  localparam logic [5:0]       RECIP_25  = 6'd41;
  localparam logic [4:0]       DIV_25    = 5'd25;

  // Volt meter: offset, steps of 51, correction at 4 volts, divide by 5 (13/64)
  localparam logic [8:0] VOLT_OFFSET = 9'd2;
  localparam logic [8:0] VOLT_STEP   = 9'd51;
  localparam logic [3:0] VOLT_FIX    = 4'd4;
  localparam logic [5:0] VOLT_FIX_LO = 6'd4;
  localparam logic [5:0] VOLT_FIX_SUB = 6'd2;
  localparam logic [3:0] RECIP_5     = 4'd13;

  // Counter digits: divide by 10 (103/1024)
  localparam logic [6:0] RECIP_10 = 7'd103;
  localparam logic [3:0] DIV_10   = 4'd10;

  // Ones digit of the value meter: (rem * 256) / 614, held at 9
  function automatic logic [DigitW-1:0] values_ones(input logic [4:0] rem);
    logic [DigitW-1:0] d;
    begin
      case (rem) inside
        [5'd0:5'd2]:   d = 4'd0;
        [5'd3:5'd4]:   d = 4'd1;
        [5'd5:5'd7]:   d = 4'd2;
        [5'd8:5'd9]:   d = 4'd3;
        [5'd10:5'd11]: d = 4'd4;
        [5'd12:5'd14]: d = 4'd5;
        [5'd15:5'd16]: d = 4'd6;
        [5'd17:5'd19]: d = 4'd7;
        [5'd20:5'd21]: d = 4'd8;
        default:       d = 4'd9;
      endcase
      return d;
    end
  endfunction

endpackage

// File: rtl/filtered_meter_and_counter_readout_top.sv
// Top level of the filtered meter and counter readout: state update and digit stages.
//
// Each transaction on the s_ side carries a tagged 10-bit reading and yields exactly one
// display transaction on the m_ side. The block takes one transaction per cycle unless m_
// stalls: the first stage applies the operation to the filter, mode and counter state (one
// 17x9 multiply for the moving average), the second stage turns the resulting state, held
// in the stage one register, into two digits in the output register. Back pressure on m_
// stalls both stages; s_tready falls only when both stages hold data. Configuration writes
// are always ready and take effect at once; write them while the stream is idle.
module filtered_meter_and_counter_readout_top (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fmcr_pkg::InDataW-1:0]   s_tdata,   // [9:0] reading, rest zero
  input  logic [fmcr_pkg::OpW-1:0]       s_tuser,   // [1:0] operation
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fmcr_pkg::OutDataW-1:0]  m_tdata,   // [3:0] lead digit, [7:4] trail digit,
                                                    // [8] decimal_on, [10:9] mode_now,
                                                    // [17:11] count_now, rest zero
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fmcr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fmcr_pkg::CfgDataW-1:0]  cfg_data
);

  // Configuration registers
  logic [fmcr_pkg::AlphaW-1:0] alpha;
  logic [fmcr_pkg::CountW-1:0] count_floor;
  logic [fmcr_pkg::CountW-1:0] count_ceiling;
  logic [fmcr_pkg::CountW-1:0] cfg_bound;

  // State
  logic signed [fmcr_pkg::AvgW-1:0] average;
  logic signed [fmcr_pkg::AvgW-1:0] average_next;
  logic [fmcr_pkg::ModeW-1:0]       mode;
  logic [fmcr_pkg::ModeW-1:0]       mode_next;
  logic [fmcr_pkg::CountW-1:0]      counter;
  logic [fmcr_pkg::CountW-1:0]      counter_next;

  // Stage one holding registers
  logic                         s1_valid;
  logic [fmcr_pkg::ByteW-1:0]   s1_byte;
  logic [fmcr_pkg::ModeW-1:0]   s1_mode;
  logic [fmcr_pkg::CountW-1:0]  s1_count;

  // Output registers
  logic                         out_valid;
  logic [fmcr_pkg::DigitW-1:0]  out_left;
  logic [fmcr_pkg::DigitW-1:0]  out_right;
  logic                         out_dp;
  logic [fmcr_pkg::ModeW-1:0]   out_mode;
  logic [fmcr_pkg::CountW-1:0]  out_count;

  // Handshake
  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free = !out_valid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign in_take  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Saturate the low seven bits of bound writes to 99
  assign cfg_bound = (cfg_data[fmcr_pkg::CountW-1:0] > fmcr_pkg::COUNT_MAX) ?
                     fmcr_pkg::COUNT_MAX : cfg_data[fmcr_pkg::CountW-1:0];

  // Moving average: avg + ((s - avg) * alpha) / 256, rounded, truncated toward zero
  logic [fmcr_pkg::ReadingW-1:0] rd;
  logic signed [fmcr_pkg::AvgW-1:0] sample;
  logic signed [16:0] diff;
  logic signed [25:0] prod;
  logic signed [26:0] acc;
  logic signed [26:0] acc_rnd;
  logic signed [26:0] acc_adj;
  logic signed [26:0] acc_shr;

  assign rd      = s_tdata[fmcr_pkg::ReadingW-1:0];
  assign sample  = {~rd[9], rd[8:0], 6'b0};
  assign diff    = 17'(sample) - 17'(average);
  assign prod    = 26'(diff) * 26'($signed({1'b0, alpha}));
  assign acc     = {{3{average[15]}}, average, 8'b0} + 27'(prod);
  assign acc_rnd = acc + 27'sd128;
  assign acc_adj = acc_rnd[26] ? (acc_rnd + 27'sd255) : acc_rnd;
  assign acc_shr = acc_adj >>> 8;

  // Next state for the accepted transaction
  always_comb begin
    average_next = average;
    mode_next    = mode;
    counter_next = counter;
    case (s_tuser)
      fmcr_pkg::OP_SAMPLE: begin
        if (mode == fmcr_pkg::MODE_VALUES || mode == fmcr_pkg::MODE_VOLTS) begin
          average_next = acc_shr[15:0];
        end
      end
      fmcr_pkg::OP_MODE: begin
        if (rd <= fmcr_pkg::THR_UP) begin
          mode_next = fmcr_pkg::MODE_UP;
        end else if (rd <= fmcr_pkg::THR_DOWN) begin
          mode_next = fmcr_pkg::MODE_DOWN;
        end else if (rd <= fmcr_pkg::THR_VALUES) begin
          mode_next = fmcr_pkg::MODE_VALUES;
        end else begin
          mode_next = fmcr_pkg::MODE_VOLTS;
        end
      end
      fmcr_pkg::OP_PULSE: begin
        if (mode == fmcr_pkg::MODE_UP && counter < count_ceiling) begin
          counter_next = counter + 7'd1;
        end else if (mode == fmcr_pkg::MODE_DOWN && counter > count_floor) begin
          counter_next = counter - 7'd1;
        end
      end
      default: begin
        if (mode == fmcr_pkg::MODE_UP) begin
          counter_next = count_floor;
        end else if (mode == fmcr_pkg::MODE_DOWN) begin
          counter_next = count_ceiling;
        end
      end
    endcase
  end

  // Configuration and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= fmcr_pkg::ALPHA_RESET;
      count_floor   <= fmcr_pkg::FLOOR_RESET;
      count_ceiling <= fmcr_pkg::CEILING_RESET;
      average       <= '0;
      mode          <= fmcr_pkg::MODE_UP;
      counter       <= fmcr_pkg::FLOOR_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          fmcr_pkg::REG_ALPHA:   alpha         <= cfg_data;
          fmcr_pkg::REG_FLOOR:   count_floor   <= cfg_bound;
          fmcr_pkg::REG_CEILING: count_ceiling <= cfg_bound;
          default: ;
        endcase
      end
      if (in_take) begin
        average <= average_next;
        mode    <= mode_next;
        counter <= counter_next;
      end
    end
  end

  // Stage one: hold the updated state until the digit stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte  <= {~average_next[15], average_next[14:8]};
      s1_mode  <= mode_next;
      s1_count <= counter_next;
    end
  end

  // Value meter digits
  logic [fmcr_pkg::ByteW-1:0]  val_g;
  logic [13:0]                 val_mul;
  logic [fmcr_pkg::DigitW-1:0] val_left;
  logic [8:0]                  val_base;
  logic [4:0]                  val_rem;

  assign val_g    = (s1_byte > fmcr_pkg::VALUE_MAX) ? fmcr_pkg::VALUE_MAX : s1_byte;
  assign val_mul  = 14'(val_g) * 14'(fmcr_pkg::RECIP_25);
  assign val_left = val_mul[13:10];
  assign val_base = 9'(val_left) * 9'(fmcr_pkg::DIV_25);
  assign val_rem  = 5'(9'(val_g) - val_base);

  // Volt meter digits
  logic [8:0]                  volt_t;
  logic [fmcr_pkg::DigitW-1:0] volt_left;
  logic [5:0]                  volt_r;
  logic [5:0]                  volt_rc;
  logic [9:0]                  volt_mul;
  logic [fmcr_pkg::DigitW-1:0] volt_right;

  assign volt_t = 9'(s1_byte) + fmcr_pkg::VOLT_OFFSET;

  // Whole volts by comparison against the step multiples (at most five)
  always_comb begin
    if (volt_t >= 9'(5 * fmcr_pkg::VOLT_STEP)) begin
      volt_left = 4'd5;
      volt_r    = 6'(volt_t - 9'(5 * fmcr_pkg::VOLT_STEP));
    end else if (volt_t >= 9'(4 * fmcr_pkg::VOLT_STEP)) begin
      volt_left = 4'd4;
      volt_r    = 6'(volt_t - 9'(4 * fmcr_pkg::VOLT_STEP));
    end else if (volt_t >= 9'(3 * fmcr_pkg::VOLT_STEP)) begin
      volt_left = 4'd3;
      volt_r    = 6'(volt_t - 9'(3 * fmcr_pkg::VOLT_STEP));
    end else if (volt_t >= 9'(2 * fmcr_pkg::VOLT_STEP)) begin
      volt_left = 4'd2;
      volt_r    = 6'(volt_t - 9'(2 * fmcr_pkg::VOLT_STEP));
    end else if (volt_t >= fmcr_pkg::VOLT_STEP) begin
      volt_left = 4'd1;
      volt_r    = 6'(volt_t - fmcr_pkg::VOLT_STEP);
    end else begin
      volt_left = 4'd0;
      volt_r    = volt_t[5:0];
    end
  end

  // Pull the tenths down by two counts in the 4 volt range when the remainder is above 4
  assign volt_rc    = (volt_left == fmcr_pkg::VOLT_FIX && volt_r > fmcr_pkg::VOLT_FIX_LO) ?
                      (volt_r - fmcr_pkg::VOLT_FIX_SUB) : volt_r;
  assign volt_mul   = 10'(volt_rc) * 10'(fmcr_pkg::RECIP_5);
  assign volt_right = (volt_mul[9:6] > 4'd9) ? 4'd9 : volt_mul[9:6];

  // Counter digits
  logic [13:0]                 cnt_mul;
  logic [fmcr_pkg::DigitW-1:0] cnt_left;
  logic [fmcr_pkg::CountW-1:0] cnt_base;
  logic [fmcr_pkg::DigitW-1:0] cnt_right;

  assign cnt_mul   = 14'(s1_count) * 14'(fmcr_pkg::RECIP_10);
  assign cnt_left  = cnt_mul[13:10];
  assign cnt_base  = 7'(cnt_left) * 7'(fmcr_pkg::DIV_10);
  assign cnt_right = 4'(s1_count - cnt_base);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_mode  <= s1_mode;
      out_count <= s1_count;
      case (s1_mode)
        fmcr_pkg::MODE_VALUES: begin
          out_left  <= val_left;
          out_right <= fmcr_pkg::values_ones(val_rem);
          out_dp    <= 1'b0;
        end
        fmcr_pkg::MODE_VOLTS: begin
          out_left  <= volt_left;
          out_right <= volt_right;
          out_dp    <= 1'b1;
        end
        default: begin
          out_left  <= cnt_left;
          out_right <= cnt_right;
          out_dp    <= 1'b0;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_count, out_mode, out_dp, out_right, out_left};

endmodule
